// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the range sum tree block.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define RASST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define RASST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rasst_pkg.sv =====
// Types and fixed constants of the range add / range sum tree block.
// Depends on nothing; imported by the top level and the shared arithmetic unit.
package rasst_pkg;

	localparam int DATA_W = 32;
	localparam int IDX_W = 10;
	localparam int CFG_W = 11;
	localparam int ACTIVE_SIZE_RESET = 1024;

	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

endpackage

// ===== hw/rtl/rasst_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module rasst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/rasst_alu.sv =====
// Shared arithmetic unit: wrapping 32-bit add, subtract and low-half multiply.
// Depends on rasst_pkg.
module rasst_alu
	import rasst_pkg::*;
(
	input  alu_op_t op,
	input  data_t   a,
	input  data_t   b,
	output data_t   y
);

	always_comb begin
		case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			ALU_MUL: y = a * b;
			default: y = a;
		endcase
	end

endmodule

// ===== hw/rtl/range_add_range_sum_tree_top.sv =====
// Top level of the range add / range sum block: sequencer, two tree RAMs and one ALU.
// Depends on rasst_pkg, rasst_ram and rasst_alu.
//
// Channel   Direction  Handshake                     Payload
// request   in         start high while busy is low  kind, left_index, right_index, add_value
// result    out        done high for one cycle       range_total
// config    in         active_size_we high           active_size
//
// An update request makes four point walks, one pair in each tree; a query request makes
// four prefix walks and then combines them. Each visited tree node takes a RAM read and
// then an ALU step, in S_CHK and S_STEP, and busy stays high for the whole request. The
// single RAM read port per tree and the one shared ALU set the length of a request.
// After reset a clearing pass writes zero to every node of both trees, with busy held
// high; configuration writes are still taken then.
// The receiver cannot stall: each result is shown for exactly one cycle.
module range_add_range_sum_tree_top
	import rasst_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                kind,
	input  logic [IDX_W-1:0]    left_index,
	input  logic [IDX_W-1:0]    right_index,
	input  logic signed [DATA_W-1:0] add_value,
	output logic                done,
	output logic signed [DATA_W-1:0] range_total,
	input  logic                active_size_we,
	input  logic [CFG_W-1:0]    active_size
);

	// Address width of the trees, and node width: the node counter must hold the active
	// size, any start position of a request, and a node after one more low-bit step.
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int SW = ($clog2(MAX_ELEMENTS + 1) > CFG_W) ? $clog2(MAX_ELEMENTS + 1) : CFG_W;
	localparam int NW = SW + 1;
	localparam logic [NW-1:0] SIZE_MAX = NW'(MAX_ELEMENTS);
	localparam logic [NW-1:0] SIZE_RST =
		NW'((MAX_ELEMENTS < ACTIVE_SIZE_RESET) ? MAX_ELEMENTS : ACTIVE_SIZE_RESET);
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ELEMENTS - 1);
	localparam logic [NW-1:0] NODE_ONE = NW'(1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_CHK,
		S_STEP,
		S_WEIGHT,
		S_FINAL
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [1:0]    walk_q;
	logic          kind_q;
	logic [NW-1:0] left_q;
	logic [NW-1:0] right_q;
	logic [NW-1:0] node_q;
	logic [NW-1:0] active_q;
	data_t         value_q;
	data_t         delta_q;
	data_t         acc_q;
	data_t         keep_q;
	data_t         total_q;
	logic          done_q;

	logic [NW-1:0] cfg_ext;
	logic [NW-1:0] cfg_lim;
	logic [NW-1:0] act_m1;
	logic [NW-1:0] left_ext;
	logic [NW-1:0] right_ext;
	logic [NW-1:0] right_p1;
	logic [NW-1:0] count;
	logic [NW-1:0] node_start;
	logic [NW-1:0] node_m1;
	logic [NW-1:0] node_next;
	logic          node_ok;
	logic [AW-1:0] mem_addr;
	logic          tree_sel;
	data_t         weight;
	data_t         left_m1;
	data_t         slope_rdata;
	data_t         offset_rdata;
	data_t         rdata;
	logic          slope_we;
	logic          offset_we;
	logic [AW-1:0] waddr;
	data_t         wdata;
	alu_op_t       alu_op;
	data_t         alu_a;
	data_t         alu_b;
	data_t         alu_y;

	// Written sizes are limited to the range one to MAX_ELEMENTS.
	always_comb begin
		cfg_ext = NW'(active_size);
		if (cfg_ext == '0) begin
			cfg_lim = NODE_ONE;
		end else if (cfg_ext > SIZE_MAX) begin
			cfg_lim = SIZE_MAX;
		end else begin
			cfg_lim = cfg_ext;
		end
	end

	// Query indices are clamped to the last element in use.
	assign act_m1    = active_q - NODE_ONE;
	assign left_ext  = NW'(left_index);
	assign right_ext = NW'(right_index);

	// The first and second walks use the first tree in an update; queries alternate trees.
	assign tree_sel = kind_q ? walk_q[0] : walk_q[1];
	assign right_p1 = right_q + NODE_ONE;
	assign count    = walk_q[1] ? left_q : right_p1;

	always_comb begin
		if (kind_q) begin
			node_start = count;
		end else if (walk_q[0]) begin
			node_start = right_p1 + NODE_ONE;
		end else begin
			node_start = left_q + NODE_ONE;
		end
	end

	// Updates climb by adding the lowest set bit and stop past the active size; prefix
	// walks descend by clearing it and stop at zero.
	assign node_m1   = node_q - NODE_ONE;
	assign node_ok   = kind_q ? (node_q != '0) : (node_q <= active_q);
	assign node_next = kind_q ? (node_q & node_m1) : (node_q + (node_q & (~node_q + NODE_ONE)));
	assign mem_addr  = node_m1[AW-1:0];

	assign weight  = DATA_W'(count) - DATA_W'(1);
	assign left_m1 = DATA_W'(left_q) - DATA_W'(1);
	assign rdata   = tree_sel ? offset_rdata : slope_rdata;

	// Operand selection for the shared ALU.
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = acc_q;
		alu_b  = '0;
		case (state_q)
			S_PREP: begin
				alu_op = ALU_MUL;
				alu_a  = value_q;
				alu_b  = walk_q[0] ? DATA_W'(right_q) : left_m1;
			end
			S_STEP: begin
				alu_op = walk_q[0] ? ALU_SUB : ALU_ADD;
				alu_a  = kind_q ? acc_q : rdata;
				alu_b  = kind_q ? rdata : delta_q;
			end
			S_WEIGHT: begin
				alu_op = ALU_MUL;
				alu_a  = acc_q;
				alu_b  = weight;
			end
			S_FINAL: begin
				alu_op = ALU_SUB;
				alu_a  = keep_q;
				alu_b  = acc_q;
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	assign slope_we  = (state_q == S_CLEAR) || ((state_q == S_STEP) && !kind_q && !tree_sel);
	assign offset_we = (state_q == S_CLEAR) || ((state_q == S_STEP) && !kind_q && tree_sel);
	assign waddr     = (state_q == S_CLEAR) ? clr_q : mem_addr;
	assign wdata     = (state_q == S_CLEAR) ? '0 : alu_y;

	rasst_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	rasst_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ELEMENTS)
	) u_slope_ram (
		.clk   (clk),
		.we    (slope_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (mem_addr),
		.rdata (slope_rdata)
	);

	rasst_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ELEMENTS)
	) u_offset_ram (
		.clk   (clk),
		.we    (offset_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (mem_addr),
		.rdata (offset_rdata)
	);

	// Sequencer: clearing pass, then one request at a time through four walks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			walk_q   <= '0;
			kind_q   <= 1'b0;
			left_q   <= '0;
			right_q  <= '0;
			node_q   <= '0;
			active_q <= SIZE_RST;
			value_q  <= '0;
			delta_q  <= '0;
			acc_q    <= '0;
			keep_q   <= '0;
			total_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (active_size_we) begin
				active_q <= cfg_lim;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						value_q <= add_value;
						walk_q  <= '0;
						acc_q   <= '0;
						if (kind) begin
							left_q  <= (left_ext > act_m1) ? act_m1 : left_ext;
							right_q <= (right_ext > act_m1) ? act_m1 : right_ext;
						end else begin
							left_q  <= left_ext;
							right_q <= right_ext;
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					node_q <= node_start;
					if (!kind_q) begin
						delta_q <= walk_q[1] ? alu_y : value_q;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (node_ok) begin
						state_q <= S_STEP;
					end else if (!kind_q) begin
						walk_q  <= walk_q + 2'd1;
						state_q <= (walk_q == 2'd3) ? S_IDLE : S_PREP;
					end else if (!walk_q[0]) begin
						state_q <= S_WEIGHT;
					end else if (walk_q == 2'd1) begin
						// The prefix sum up to the right end is complete; keep it aside.
						keep_q  <= acc_q;
						acc_q   <= '0;
						walk_q  <= 2'd2;
						state_q <= S_PREP;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_STEP: begin
					if (kind_q) begin
						acc_q <= alu_y;
					end
					node_q  <= node_next;
					state_q <= S_CHK;
				end
				S_WEIGHT: begin
					acc_q   <= alu_y;
					walk_q  <= walk_q + 2'd1;
					state_q <= S_PREP;
				end
				S_FINAL: begin
					total_q <= alu_y;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign range_total = signed'(total_q);

endmodule

// ===== hw/rtl/rasst_checker.sv =====
// Port-level assertions for the range sum tree block, bound to its top level.
// Depends on assert_macros.svh and range_add_range_sum_tree_top.
`include "assert_macros.svh"

module rasst_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	`RASST_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "busy did not rise after an accepted request")
	`RASST_ASSERT(a_no_early_done, clk, arst_n, (start && !busy) |=> !done, "result shown in the cycle after acceptance")
	`RASST_ASSERT(a_done_pulse, clk, arst_n, done |=> !done, "result strobe held for more than one cycle")
	`RASST_ASSERT(a_done_after_work, clk, arst_n, done |-> $past(busy), "result shown without work in progress")
	`RASST_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !done, "result strobe during reset")

endmodule

bind range_add_range_sum_tree_top rasst_checker u_rasst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// ===== tb/tb_range_add_range_sum_tree_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for range_add_range_sum_tree_top: range updates and range-sum queries
// checked against a behavioural pair of index trees kept in a small scoreboard class.
// Depends on rasst_pkg and the range_add_range_sum_tree_top RTL.

import rasst_pkg::*;

typedef enum bit {
	REQ_ADD   = 1'b0,
	REQ_QUERY = 1'b1
} req_kind_e;

// Shadow of the block: two index trees at the block's widths, the active size, and the
// queue of range totals that queries have yet to return.
class range_sum_scoreboard;
	localparam int SLOPE = 0;
	localparam int OFFSET = 1;
	localparam int ELEMENTS = ACTIVE_SIZE_RESET;

	bit [DATA_W-1:0] nodes [2][ELEMENTS];
	int unsigned elems;
	data_t totals_due [$];
	int unsigned mismatches;

	function new();
		elems = ELEMENTS;
		mismatches = 0;
	endfunction

	function void set_size(bit [CFG_W-1:0] v);
		if (v == 0) begin
			elems = 1;
		end else if (v > ELEMENTS) begin
			elems = ELEMENTS;
		end else begin
			elems = 32'(v);
		end
	endfunction

	// Point update; positions at or past the active size fall off the end of the walk.
	function void scatter(int t, bit [31:0] pos, bit [31:0] delta);
		bit [31:0] node;
		node = pos + 1;
		while (node >= 1 && node <= elems) begin
			nodes[t][node-1] += delta;
			node += node & (~node + 1);
		end
	endfunction

	// Sum of the first count tree positions, bounded by the active size.
	function bit [31:0] gather(int t, bit [31:0] count);
		bit [31:0] node;
		bit [31:0] acc;
		node = (count > elems) ? elems : count;
		acc = '0;
		while (node > 0) begin
			acc += nodes[t][node-1];
			node &= node - 1;
		end
		return acc;
	endfunction

	// Sum of array elements 0..count-1, wrapped to 32 bits.
	function bit [31:0] element_sum(bit [31:0] count);
		if (count == 0)
			return '0;
		return gather(SLOPE, count) * (count - 1) - gather(OFFSET, count);
	endfunction

	function void note_request(req_kind_e k, bit [IDX_W-1:0] l, bit [IDX_W-1:0] r,
			bit [DATA_W-1:0] v);
		bit [31:0] lo;
		bit [31:0] hi;
		data_t due;
		lo = 32'(l);
		hi = 32'(r);
		if (k == REQ_ADD) begin
			scatter(SLOPE, lo, v);
			scatter(SLOPE, hi + 1, -v);
			scatter(OFFSET, lo, v * (lo - 1));
			scatter(OFFSET, hi + 1, -(v * hi));
		end else begin
			if (lo > elems - 1)
				lo = elems - 1;
			if (hi > elems - 1)
				hi = elems - 1;
			due = element_sum(hi + 1) - element_sum(lo);
			totals_due = {totals_due, due};
		end
	endfunction

	function void check_total(data_t got);
		data_t want;
		if (totals_due.size() == 0) begin
			mismatches++;
			$error("range_total: no query outstanding, actual %0d", $signed(got));
		end else begin
			want = totals_due.pop_front();
			if (want !== got) begin
				mismatches++;
				$error("range_total: expected %0d, actual %0d", $signed(want), $signed(got));
			end
		end
	endfunction

	function int pending();
		return totals_due.size();
	endfunction
endclass

module tb_range_add_range_sum_tree_top;

	// Number of random requests in each phase; seven phases give about 1750 in all.
	localparam int PHASE_REQS = 250;
	localparam int PHASES = 7;
	// This many quiet cycles after the last query result are enough for a trailing update
	// to finish its walks.
	localparam int SETTLE_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	logic [IDX_W-1:0] left_index = '0;
	logic [IDX_W-1:0] right_index = '0;
	logic signed [DATA_W-1:0] add_value = '0;
	logic done;
	logic signed [DATA_W-1:0] range_total;
	logic active_size_we = 1'b0;
	logic [CFG_W-1:0] active_size = '0;

	range_sum_scoreboard sb = new();

	// Requests remaining in the sender's current burst before it goes quiet for a while.
	int burst_left = 1;

	range_add_range_sum_tree_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.left_index     (left_index),
		.right_index    (right_index),
		.add_value      (add_value),
		.done           (done),
		.range_total    (range_total),
		.active_size_we (active_size_we),
		.active_size    (active_size)
	);

	always #10 clk = ~clk;

	// Results cannot be held off, so every cycle with done high carries one total. Values are
	// read at the edge, before any update that the same edge brings.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_total(range_total);
	end

	// Present one request and hold it until the block takes it. Within a burst start stays high
	// into the next request; when the burst runs out start drops for a random, nonzero gap, so
	// the next raise never shares a time step with the fall. Gaps range from short pauses up
	// to more than a whole request, so they land on every stage of the walks.
	task automatic send_request(req_kind_e k, bit [IDX_W-1:0] l, bit [IDX_W-1:0] r,
			bit [DATA_W-1:0] v);
		int gap;
		start <= 1'b1;
		kind <= k;
		left_index <= l;
		right_index <= r;
		add_value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(k, l, r, v);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			start <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 12);
		end
	endtask

	// Called in the time step of the last accepted request: start falls at once so no
	// untracked request can slip in. The size is changed only once every query has answered
	// and any trailing update has had time to finish.
	task automatic drain_and_resize(bit [CFG_W-1:0] v);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		active_size_we <= 1'b1;
		active_size <= v;
		sb.set_size(v);
		@(posedge clk);
		active_size_we <= 1'b0;
	endtask

	initial begin
		int sizes [PHASES];
		int eff;
		int a;
		int b;
		bit [IDX_W-1:0] lo;
		bit [IDX_W-1:0] hi;
		data_t val;
		req_kind_e k;

		// Reset falls in the first time step, so the block is reset before the first edge.
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset size. The block first clears both trees, and the
		// first request simply waits on busy until that is over.
		send_request(REQ_ADD, 0, 1023, 32'h7FFF_FFFF);
		send_request(REQ_QUERY, 0, 1023, $urandom);
		send_request(REQ_QUERY, 0, 0, $urandom);
		send_request(REQ_QUERY, 1023, 1023, $urandom);
		send_request(REQ_ADD, 0, 0, 32'h8000_0000);
		// The closing point update of this one lands just past the array and is dropped.
		send_request(REQ_ADD, 1023, 1023, 32'hFFFF_FFFF);
		// Reversed ranges are taken as they stand, for updates and queries alike.
		send_request(REQ_ADD, 700, 300, 32'd5);
		send_request(REQ_QUERY, 600, 100, $urandom);
		send_request(REQ_QUERY, 512, 767, $urandom);
		send_request(REQ_ADD, 1, 1022, 32'd1);
		send_request(REQ_QUERY, 1, 1022, $urandom);

		// A small array: updates reaching past it lose their outer point updates, and query
		// indices beyond it are pulled back to the last element.
		drain_and_resize(16);
		send_request(REQ_ADD, 10, 40, 32'hDEAD_BEEF);
		send_request(REQ_ADD, 100, 200, 32'd7);
		send_request(REQ_QUERY, 3, 900, $urandom);
		send_request(REQ_QUERY, 900, 1000, $urandom);
		send_request(REQ_QUERY, 0, 15, $urandom);

		// A size of zero is taken as one element.
		drain_and_resize(0);
		send_request(REQ_QUERY, 0, 0, $urandom);
		send_request(REQ_ADD, 0, 1, 32'd3);
		send_request(REQ_QUERY, 0, 5, $urandom);

		// An oversize write gives the full array back; nodes written earlier are kept.
		drain_and_resize(2047);
		send_request(REQ_QUERY, 0, 1023, $urandom);
		send_request(REQ_QUERY, 10, 20, $urandom);

		// Random phases, each at its own size, the extremes among them.
		sizes = '{1024, $urandom_range(1, 64), 0, 2047, $urandom_range(1, 2047), 2,
			$urandom_range(3, 1024)};
		for (int p = 0; p < PHASES; p++) begin
			drain_and_resize(CFG_W'(sizes[p]));
			eff = sb.elems;
			for (int n = 0; n < PHASE_REQS; n++) begin
				k = req_kind_e'($urandom_range(0, 1));
				a = $urandom_range(0, eff - 1);
				b = $urandom_range(0, eff - 1);
				case ($urandom_range(0, 9))
					7: begin
						// Anywhere in the index field, past the array or reversed.
						lo = IDX_W'($urandom);
						hi = IDX_W'($urandom);
					end
					8: begin
						lo = IDX_W'((a > b) ? a : b);
						hi = IDX_W'((a > b) ? b : a);
					end
					9: begin
						lo = IDX_W'($urandom_range(0, 1) ? 0 : eff - 1);
						hi = IDX_W'($urandom_range(0, 1) ? eff - 1 : 1023);
					end
					default: begin
						lo = IDX_W'((a < b) ? a : b);
						hi = IDX_W'((a < b) ? b : a);
					end
				endcase
				case ($urandom_range(0, 3))
					0: val = $urandom_range(0, 200) - 100;
					3: begin
						case ($urandom_range(0, 4))
							0: val = 32'h7FFF_FFFF;
							1: val = 32'h8000_0000;
							2: val = 32'hFFFF_FFFF;
							3: val = '0;
							default: val = 32'd1;
						endcase
					end
					default: val = $urandom;
				endcase
				send_request(k, lo, hi, val);
			end
		end

		// Wait for the last totals, then long enough for a trailing update to finish too.
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog: a time limit several times the slowest correct run.
	initial begin
		#100_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
